/* hdl/bsc_pkg.sv */
package bsc_pkg;

  localparam int NUM_BATCHES = 16;
  localparam int CACHE_SLOTS = 5;

  localparam int SLOT_W  = 3;
  localparam int ID_W    = 8;
  localparam int VER_W   = 8;
  localparam int BATCH_W = (NUM_BATCHES > 1) ? $clog2(NUM_BATCHES) : 1;
  localparam int DEPTH   = NUM_BATCHES * CACHE_SLOTS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_BIND        = 2'd0,
    OP_CLEAR       = 2'd1,
    OP_RESET_BATCH = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ACT_RD,
    S_ACT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WRITE,
    S_CLR,
    S_OUT
  } state_t;

endpackage

/* hdl/bsc_ram.sv */
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/binding_slot_cache_unit.sv */
// Binding slot cache: each batch keeps a few (program id, version) slots, an
// active slot and a round-robin next pointer, and tells whether a bind must
// rebuild the binding.
// Input channel (in_valid/in_ready): opcode, batch_id, program_id,
// program_version. Opcodes: bind, clear all versions of a batch, reset batch.
// Output channel (out_valid/out_ready): needs_rebuild, active_slot_out, one
// result transaction for every input transaction.
// One operation is worked at a time through a small sequencer around one
// slot RAM read port and one id/version compare. A bind checks the active
// slot, on a miss scans the slots in order, then writes one slot; a clear
// zeroes each version in turn, a reset batch does one write. in_ready is
// high only while the block is idle, so the next transaction is taken no
// earlier than the cycle after the result is taken.
// After reset every slot reads as empty (id 0, version 0), active and next
// pointers are 0; no clearing pass is needed, valid bits cover the slots.
// A stalled receiver holds the result in the output register and the block
// takes no new transaction until the result is taken.
module binding_slot_cache_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [3:0]                  batch_id,
  input  logic [bsc_pkg::ID_W-1:0]    program_id,
  input  logic [bsc_pkg::VER_W-1:0]   program_version,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        needs_rebuild,
  output logic [bsc_pkg::SLOT_W-1:0]  active_slot_out
);

  import bsc_pkg::*;

  state_t state, state_next;

  // latched transaction
  logic [1:0]         op;
  logic [BATCH_W-1:0] batch;
  logic [ADDR_W-1:0]  base, base_next;
  logic [ID_W-1:0]    pid;
  logic [VER_W-1:0]   pver;

  logic [SLOT_W-1:0]  idx, idx_next;
  logic               rebuild, rebuild_next;
  logic [SLOT_W-1:0]  slot_res, slot_res_next;

  // per-batch pointers
  logic [SLOT_W-1:0]  active_arr [NUM_BATCHES];
  logic [SLOT_W-1:0]  next_arr   [NUM_BATCHES];
  logic               act_we, nxt_we;
  logic [SLOT_W-1:0]  act_wd, nxt_wd;

  // slot storage with valid bits standing in for the reset value
  logic [DEPTH-1:0]   prog_vld, ver_vld;
  logic               rd_pvld, rd_vvld;
  logic               wr_prog_en, wr_ver_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ID_W-1:0]    wr_prog_data, prog_q, prog_rd;
  logic [VER_W-1:0]   wr_ver_data, ver_q, ver_rd;

  logic [BATCH_W-1:0] batch_sel;
  logic [SLOT_W-1:0]  act_raw, act_cl, nxt_raw, nxt_cl;

  bsc_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prog_ram (
    .clk     (clk),
    .wr_en   (wr_prog_en),
    .wr_addr (wr_addr),
    .wr_data (wr_prog_data),
    .rd_addr (rd_addr),
    .rd_data (prog_q)
  );

  bsc_ram #(.WIDTH(VER_W), .DEPTH(DEPTH)) u_ver_ram (
    .clk     (clk),
    .wr_en   (wr_ver_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ver_data),
    .rd_addr (rd_addr),
    .rd_data (ver_q)
  );

  assign prog_rd = rd_pvld ? prog_q : '0;
  assign ver_rd  = rd_vvld ? ver_q  : '0;

  // out-of-range batch falls back to batch 0
  assign batch_sel = (32'(batch_id) < NUM_BATCHES) ? BATCH_W'(batch_id) : '0;
  assign base_next = ADDR_W'(32'(batch_sel) * CACHE_SLOTS);

  // pointers of the latched batch, clamped where used as slot index
  assign act_raw = active_arr[batch];
  assign act_cl  = (32'(act_raw) >= CACHE_SLOTS) ? '0 : act_raw;
  assign nxt_raw = next_arr[batch];
  assign nxt_cl  = (32'(nxt_raw) >= CACHE_SLOTS) ? '0 : nxt_raw;

  assign rd_addr = base + ADDR_W'(idx);
  assign wr_addr = base + ADDR_W'(idx);

  assign in_ready        = (state == S_IDLE);
  assign out_valid       = (state == S_OUT);
  assign needs_rebuild   = rebuild;
  assign active_slot_out = slot_res;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prog_vld <= '0;
      ver_vld  <= '0;
      for (int i = 0; i < NUM_BATCHES; i++) begin
        active_arr[i] <= '0;
        next_arr[i]   <= '0;
      end
    end else begin
      state <= state_next;
      if (wr_prog_en) prog_vld[wr_addr] <= 1'b1;
      if (wr_ver_en)  ver_vld[wr_addr]  <= 1'b1;
      if (act_we)     active_arr[batch] <= act_wd;
      if (nxt_we)     next_arr[batch]   <= nxt_wd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op    <= opcode;
      batch <= batch_sel;
      base  <= base_next;
      pid   <= program_id;
      pver  <= program_version;
    end
    idx      <= idx_next;
    rebuild  <= rebuild_next;
    slot_res <= slot_res_next;
    rd_pvld  <= prog_vld[rd_addr];
    rd_vvld  <= ver_vld[rd_addr];
  end

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    rebuild_next  = rebuild;
    slot_res_next = slot_res;
    wr_prog_en    = 1'b0;
    wr_ver_en     = 1'b0;
    wr_prog_data  = pid;
    wr_ver_data   = pver;
    act_we        = 1'b0;
    act_wd        = idx;
    nxt_we        = 1'b0;
    nxt_wd        = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end

      S_START: begin
        rebuild_next  = 1'b0;
        slot_res_next = act_raw;
        case (op)
          OP_BIND: begin
            idx_next   = act_cl;
            state_next = S_ACT_RD;
          end
          OP_CLEAR: begin
            idx_next   = '0;
            state_next = S_CLR;
          end
          OP_RESET_BATCH: begin
            // idx may hold any slot here; address slot 0 via idx_next path
            idx_next      = '0;
            slot_res_next = '0;
            act_we        = 1'b1;
            act_wd        = '0;
            nxt_we        = 1'b1;
            nxt_wd        = SLOT_W'(1);
            state_next    = S_WRITE;
          end
          default: state_next = S_OUT;
        endcase
      end

      // read the active slot
      S_ACT_RD: state_next = S_ACT_CHK;

      S_ACT_CHK: begin
        if (prog_rd == pid && ver_rd == pver) begin
          rebuild_next  = 1'b0;
          slot_res_next = idx;
          state_next    = S_OUT;
        end else begin
          idx_next   = '0;
          state_next = S_SCAN_RD;
        end
      end

      // scan slots for the id or an empty slot
      S_SCAN_RD: state_next = S_SCAN_CHK;

      S_SCAN_CHK: begin
        if (prog_rd == pid) begin
          rebuild_next = (ver_rd != pver);
          state_next   = S_WRITE;
        end else if (prog_rd == '0) begin
          rebuild_next = 1'b1;
          state_next   = S_WRITE;
        end else if (32'(idx) == CACHE_SLOTS - 1) begin
          // no match: round-robin victim
          rebuild_next = 1'b1;
          idx_next     = nxt_cl;
          nxt_we       = 1'b1;
          nxt_wd       = SLOT_W'(nxt_cl + SLOT_W'(1));
          state_next   = S_WRITE;
        end else begin
          idx_next   = SLOT_W'(idx + SLOT_W'(1));
          state_next = S_SCAN_RD;
        end
      end

      S_WRITE: begin
        wr_prog_en = 1'b1;
        if (op == OP_RESET_BATCH) begin
          wr_prog_data = '0;
        end else begin
          wr_ver_en     = 1'b1;
          act_we        = 1'b1;
          act_wd        = idx;
          slot_res_next = idx;
        end
        state_next = S_OUT;
      end

      // zero every version of the batch, one slot a cycle
      S_CLR: begin
        wr_ver_en   = 1'b1;
        wr_ver_data = '0;
        if (32'(idx) == CACHE_SLOTS - 1) begin
          state_next = S_OUT;
        end else begin
          idx_next = SLOT_W'(idx + SLOT_W'(1));
        end
      end

      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* tb/sv/binding_slot_cache_unit_test.sv */
`timescale 1ns / 100ps

module binding_slot_cache_unit_test;
  import bsc_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE_LEN   = 40;
  localparam int SEG_ITEMS    = 215;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic              rebuild;
    logic [SLOT_W-1:0] slot;
  } bind_result_t;

  // Shadow copy of the slot cache plus the queue of results still owed
  class slot_cache_board;
    logic [ID_W-1:0]   slot_id  [NUM_BATCHES][CACHE_SLOTS];
    logic [VER_W-1:0]  slot_ver [NUM_BATCHES][CACHE_SLOTS];
    logic [SLOT_W-1:0] active   [NUM_BATCHES];
    logic [SLOT_W-1:0] next_rr  [NUM_BATCHES];
    bind_result_t      pending_results[$];
    int errors;
    int results_seen;
    int binds;
    int rebuilds;
    int evictions;
    int clears;
    int batch_resets;

    function new();
      for (int b = 0; b < NUM_BATCHES; b++) begin
        active[b]  = '0;
        next_rr[b] = '0;
        for (int s = 0; s < CACHE_SLOTS; s++) begin
          slot_id[b][s]  = '0;
          slot_ver[b][s] = '0;
        end
      end
    endfunction

    // Active slot check, then scan for id or empty slot, then round robin
    function bind_result_t bind_program(int b, logic [ID_W-1:0] id,
                                        logic [VER_W-1:0] ver);
      bind_result_t      r;
      logic [SLOT_W-1:0] cur;
      logic [SLOT_W-1:0] pick;
      bit                found;
      r.rebuild = 1'b1;
      cur = active[b];
      if (cur >= CACHE_SLOTS) cur = '0;
      if (slot_id[b][cur] == id && slot_ver[b][cur] == ver) begin
        r.rebuild = 1'b0;
        r.slot    = cur;
        return r;
      end
      found = 1'b0;
      pick  = '0;
      for (int s = 0; s < CACHE_SLOTS && !found; s++) begin
        if (slot_id[b][s] == id) begin
          found     = 1'b1;
          pick      = s[SLOT_W-1:0];
          r.rebuild = (slot_ver[b][s] != ver);
        end else if (slot_id[b][s] == '0) begin
          found = 1'b1;
          pick  = s[SLOT_W-1:0];
        end
      end
      if (!found) begin
        pick = next_rr[b];
        if (pick >= CACHE_SLOTS) pick = '0;
        next_rr[b] = pick + 1'b1;
        evictions++;
      end
      slot_id[b][pick]  = id;
      slot_ver[b][pick] = ver;
      active[b]         = pick;
      r.slot            = pick;
      return r;
    endfunction

    function void note_request(logic [1:0] op, logic [3:0] batch,
                               logic [ID_W-1:0] id, logic [VER_W-1:0] ver);
      bind_result_t r;
      int           bi;
      bi = batch;
      if (bi >= NUM_BATCHES) bi = 0;
      r.rebuild = 1'b0;
      r.slot    = active[bi];
      case (op)
        OP_BIND: begin
          r = bind_program(bi, id, ver);
          binds++;
          if (r.rebuild) rebuilds++;
        end
        OP_CLEAR: begin
          for (int s = 0; s < CACHE_SLOTS; s++) slot_ver[bi][s] = '0;
          clears++;
        end
        OP_RESET_BATCH: begin
          active[bi]     = '0;
          next_rr[bi]    = SLOT_W'(1);
          slot_id[bi][0] = '0;
          r.slot         = '0;
          batch_resets++;
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic nr, logic [SLOT_W-1:0] slot);
      bind_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: needs_rebuild=%b active_slot_out=%0d",
                 $time, nr, slot);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (nr !== want.rebuild) begin
        $display("%0t: needs_rebuild mismatch: expected %b, actual %b",
                 $time, want.rebuild, nr);
        errors++;
      end
      if (slot !== want.slot) begin
        $display("%0t: active_slot_out mismatch: expected %0d, actual %0d",
                 $time, want.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode = '0;
  logic [3:0]        batch_id = '0;
  logic [ID_W-1:0]   program_id = '0;
  logic [VER_W-1:0]  program_version = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              needs_rebuild;
  logic [SLOT_W-1:0] active_slot_out;

  slot_cache_board board = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  binding_slot_cache_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .batch_id        (batch_id),
    .program_id      (program_id),
    .program_version (program_version),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .needs_rebuild   (needs_rebuild),
    .active_slot_out (active_slot_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_request(opcode, batch_id, program_id, program_version);
      if (out_valid && out_ready)
        board.check_result(needs_rebuild, active_slot_out);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transaction in %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one operation, idling first at the current sender rate
  task automatic send_item(input logic [1:0] op, input logic [3:0] batch,
                           input logic [ID_W-1:0] id, input logic [VER_W-1:0] ver);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    batch_id        <= batch;
    program_id      <= id;
    program_version <= ver;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly binds from a small id/version pool so hits, stale versions and
  // evictions all come up; the rest is wide random content
  task automatic send_random_item();
    int         r_op;
    int         r_b;
    int         r_id;
    int         r_ver;
    logic [1:0] op;
    r_op = $urandom_range(99);
    if (r_op < 80) op = OP_BIND;
    else if (r_op < 90) op = OP_CLEAR;
    else op = OP_RESET_BATCH;
    r_b = $urandom_range(1) ? $urandom_range(2) : $urandom_range(15);
    r_id = $urandom_range(99);
    if (r_id < 85) r_id = $urandom_range(7, 1);
    else if (r_id < 90) r_id = 0;
    else r_id = $urandom_range(255);
    r_ver = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(255);
    send_item(op, r_b[3:0], r_id[ID_W-1:0], r_ver[VER_W-1:0]);
  endtask

  // Drop valid and wait for every owed result
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset-state hit, empty slot fill, active hit, stale version,
    // round robin eviction, id hit away from active, clear, batch reset
    send_item(OP_BIND, 4'd0, 8'd0, 8'd0);
    send_item(OP_BIND, 4'd3, 8'd1, 8'd0);
    send_item(OP_BIND, 4'd3, 8'd1, 8'd0);
    send_item(OP_BIND, 4'd3, 8'd1, 8'd5);
    send_item(OP_BIND, 4'd3, 8'd2, 8'd7);
    send_item(OP_BIND, 4'd3, 8'd3, 8'd9);
    send_item(OP_BIND, 4'd3, 8'd4, 8'd1);
    send_item(OP_BIND, 4'd3, 8'd5, 8'd2);
    send_item(OP_BIND, 4'd3, 8'd6, 8'd3);
    send_item(OP_BIND, 4'd3, 8'd7, 8'd3);
    send_item(OP_BIND, 4'd3, 8'd4, 8'd1);
    send_item(OP_CLEAR, 4'd3, 8'd0, 8'd0);
    send_item(OP_BIND, 4'd3, 8'd4, 8'd1);
    send_item(OP_RESET_BATCH, 4'd3, 8'd0, 8'd0);
    send_item(OP_BIND, 4'd3, 8'd0, 8'd0);
    send_item(OP_BIND, 4'd15, 8'd255, 8'd255);
    send_item(OP_BIND, 4'd15, 8'd255, 8'd255);
    send_item(OP_BIND, 4'd15, 8'd255, 8'd0);
    send_item(OP_CLEAR, 4'd15, 8'd255, 8'd255);
    send_item(OP_RESET_BATCH, 4'd15, 8'd255, 8'd255);
    send_item(OP_BIND, 4'd15, 8'd170, 8'd85);
    send_item(OP_BIND, 4'd8, 8'd85, 8'd170);
    send_item(OP_RESET_BATCH, 4'd0, 8'd0, 8'd0);
    send_item(OP_CLEAR, 4'd0, 8'd0, 8'd0);
    wait_for_results();

    // Random segments cycling through the idle mixes
    for (int seg = 0; seg < 8; seg++) begin
      mode = seg % 4;
      send_idle_pct  = (mode == 1) ? 68 : (mode == 3) ? 16 : 0;
      recv_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 16 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (mode == 2 && n == 20) hold_left = HOLD_CYCLES;
        send_random_item();
      end
      wait_for_results();
    end

    repeat (SETTLE_LEN) @(posedge clk);
    $display("Covered %0d transactions: %0d binds (%0d rebuilds, %0d evictions),",
             board.results_seen, board.binds, board.rebuilds, board.evictions);
    $display("  %0d clears, %0d batch resets, under mixed idle and stall rates",
             board.clears, board.batch_resets);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
